@@ rtl/ogs_pkg.sv @@
`timescale 1ns / 1ps
// Occupancy grid store: shared types, constants and register indexes.
// Used by every module of the block except ogs_ram; depends on nothing.

package ogs_pkg;

   // Grid geometry and coordinate format
   localparam int MAX_ROWS        = 256;
   localparam int MAX_COLS        = 256;
   localparam int COORD_FRAC_BITS = 16;
   localparam int ROW_AW          = $clog2(MAX_ROWS);
   localparam int COL_AW          = $clog2(MAX_COLS);
   localparam int USED_W          = 9;

   // Index arithmetic widths
   localparam int DIFF_W = 34;
   localparam int MAG_W  = 33;
   localparam int PROD_W = 65;
   localparam int QMAG_W = 41;
   localparam int IDX_W  = 42;
   localparam int SHIFT  = 2 * COORD_FRAC_BITS;
   localparam logic [PROD_W-1:0] REM_MASK = (PROD_W'(1) << SHIFT) - PROD_W'(1);
   localparam logic [QMAG_W-1:0] IDX_SAT  = QMAG_W'(1) << 40;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INV_CELL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_ROWS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS = 3'd4;

   // Neighbour directions
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_CLR   = 2'd1,
      OP_QUERY = 2'd2,
      OP_NBR   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      K_MARK,
      K_SKIP,
      K_QFIX,
      K_QSCAN,
      K_NBR
   } kind_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_CALC,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_CLEAR,
      B_IDLE,
      B_MARK_RD,
      B_MARK_WR,
      B_RESP,
      B_SCAN,
      B_NB_RD,
      B_NB_CHK,
      B_NB_OUT
   } back_state_type;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [30:0]        radius;
      logic [7:0]         cell_row;
      logic [7:0]         cell_col;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic       nbr_found;
      logic [7:0] nbr_row;
      logic [7:0] nbr_col;
      logic [1:0] nbr_dir;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic [31:0]        inv_cell_size;
      logic [USED_W-1:0]  rows_used;
      logic [USED_W-1:0]  cols_used;
   } cfg_type;

   // One classified item on its way from front to back
   typedef struct packed {
      kind_type          kind;
      logic              flag;   // mark value, or fixed query answer
      logic [ROW_AW-1:0] r_lo;
      logic [ROW_AW-1:0] r_hi;
      logic [COL_AW-1:0] c_lo;
      logic [COL_AW-1:0] c_hi;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

@@ rtl/ogs_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.

module ogs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ogs_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts items, maps coordinates to cell indexes through a
// five-stage multiply pipeline and classifies each item. Uses ogs_pkg.

module ogs_front (
   input  logic                     clock,
   input  logic                     reset,
   input  ogs_pkg::cfg_type         cfg,
   input  ogs_pkg::back_status_type status,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ogs_pkg::req_type         req_data,
   output logic                     push_valid,
   input  logic                     push_ready,
   output ogs_pkg::cmd_type         push_data
);

   ogs_pkg::front_state_type state_ff, state_in;
   ogs_pkg::req_type         item_ff;
   logic [2:0]               cnt_ff;
   logic                     issue;
   logic                     accept;

   logic                             s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic [1:0]                       s1_tag_ff, s2_tag_ff, s3_tag_ff, s4_tag_ff;
   logic signed [ogs_pkg::DIFF_W-1:0] s1_diff_ff;
   logic                             s2_neg_ff, s3_neg_ff, s4_neg_ff;
   logic [ogs_pkg::MAG_W-1:0]        s2_mag_ff;
   logic [63:0]                      s3_prod_ff;
   logic                             s3_hi_ff;
   logic [ogs_pkg::QMAG_W-1:0]       s4_q_ff;
   logic                             s4_rem_ff;
   logic signed [ogs_pkg::IDX_W-1:0] idx_ff [4];

   logic signed [ogs_pkg::DIFF_W-1:0] pos_s, org_s, rad_s, diff_in;
   logic [ogs_pkg::DIFF_W-1:0]        neg_diff;
   logic [ogs_pkg::MAG_W-1:0]         mag_in;
   logic [63:0]                       prod_in;
   logic [ogs_pkg::PROD_W-1:0]        p_sum, q_full;
   logic [ogs_pkg::QMAG_W-1:0]        q_in;
   logic                              rem_in;
   logic [ogs_pkg::IDX_W-1:0]         neg_t;
   logic signed [ogs_pkg::IDX_W-1:0]  idx_in;

   logic signed [ogs_pkg::IDX_W-1:0] r0, r1, c0, c1, rows_s, cols_s;
   logic                             cell_in, box_empty, box_out;

   assign accept = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ogs_pkg::F_IDLE: begin
            if (accept) begin
               state_in = (req_data.op == ogs_pkg::OP_NBR) ? ogs_pkg::F_PUSH
                                                           : ogs_pkg::F_CALC;
            end
         end
         ogs_pkg::F_CALC: begin
            if (s4_vld_ff && s4_tag_ff == 2'd3) begin
               state_in = ogs_pkg::F_PUSH;
            end
         end
         ogs_pkg::F_PUSH: begin
            if (push_ready) begin
               state_in = ogs_pkg::F_IDLE;
            end
         end
         default: state_in = ogs_pkg::F_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready  = 1'b0;
      push_valid = 1'b0;
      issue      = 1'b0;
      case (state_ff)
         ogs_pkg::F_IDLE: req_ready  = !status.clearing;
         ogs_pkg::F_CALC: issue      = !cnt_ff[2];
         ogs_pkg::F_PUSH: push_valid = 1'b1;
         default: ;
      endcase
   end

   // Stage 1: offset from origin, tag 0/1 rows (minus/plus radius), 2/3 columns
   always_comb begin
      pos_s = cnt_ff[1] ? {{2{item_ff.pos_x[31]}}, item_ff.pos_x}
                        : {{2{item_ff.pos_y[31]}}, item_ff.pos_y};
      org_s = cnt_ff[1] ? {{2{cfg.origin_x[31]}}, cfg.origin_x}
                        : {{2{cfg.origin_y[31]}}, cfg.origin_y};
      rad_s = (item_ff.op == ogs_pkg::OP_QUERY) ? {3'b000, item_ff.radius} : '0;
      diff_in = pos_s - org_s + (cnt_ff[0] ? rad_s : -rad_s);
   end

   // Stage 2: sign and magnitude
   assign neg_diff = -s1_diff_ff;
   assign mag_in   = s1_diff_ff[ogs_pkg::DIFF_W-1] ? neg_diff[ogs_pkg::MAG_W-1:0]
                                                   : s1_diff_ff[ogs_pkg::MAG_W-1:0];

   // Stage 3: low 32 bits of the magnitude times the scale; top bit is a select
   assign prod_in = s2_mag_ff[31:0] * cfg.inv_cell_size;

   // Stage 4: fold in the top bit, drop the fraction, saturate
   always_comb begin
      p_sum  = {1'b0, s3_prod_ff}
             + (s3_hi_ff ? {1'b0, cfg.inv_cell_size, 32'b0} : '0);
      q_full = p_sum >> ogs_pkg::SHIFT;
      rem_in = |(p_sum & ogs_pkg::REM_MASK);
      q_in   = (q_full > ogs_pkg::PROD_W'(ogs_pkg::IDX_SAT)) ? ogs_pkg::IDX_SAT
                                                           : q_full[ogs_pkg::QMAG_W-1:0];
   end

   // Stage 5: floor for negative offsets, clamp at the negative limit
   always_comb begin
      neg_t = {1'b0, s4_q_ff} + ogs_pkg::IDX_W'(s4_rem_ff);
      if (!s4_neg_ff) begin
         idx_in = {1'b0, s4_q_ff};
      end else if (neg_t > {1'b0, ogs_pkg::IDX_SAT}) begin
         idx_in = -{1'b0, ogs_pkg::IDX_SAT};
      end else begin
         idx_in = -neg_t;
      end
   end

   // Classification
   always_comb begin
      r0     = idx_ff[0];
      r1     = idx_ff[1];
      c0     = idx_ff[2];
      c1     = idx_ff[3];
      rows_s = ogs_pkg::IDX_W'(cfg.rows_used);
      cols_s = ogs_pkg::IDX_W'(cfg.cols_used);
      cell_in   = !r0[ogs_pkg::IDX_W-1] && !c0[ogs_pkg::IDX_W-1]
               && (r0 < rows_s) && (c0 < cols_s);
      box_empty = (r0 > r1) || (c0 > c1);
      box_out   = r0[ogs_pkg::IDX_W-1] || c0[ogs_pkg::IDX_W-1]
               || (r1 >= rows_s) || (c1 >= cols_s);

      push_data.flag = 1'b0;
      push_data.r_lo = r0[ogs_pkg::ROW_AW-1:0];
      push_data.r_hi = r1[ogs_pkg::ROW_AW-1:0];
      push_data.c_lo = c0[ogs_pkg::COL_AW-1:0];
      push_data.c_hi = c1[ogs_pkg::COL_AW-1:0];
      case (item_ff.op)
         ogs_pkg::OP_SET, ogs_pkg::OP_CLR: begin
            push_data.kind = cell_in ? ogs_pkg::K_MARK : ogs_pkg::K_SKIP;
            push_data.flag = (item_ff.op == ogs_pkg::OP_SET);
         end
         ogs_pkg::OP_QUERY: begin
            if (box_empty) begin
               push_data.kind = ogs_pkg::K_QFIX;
            end else if (box_out) begin
               push_data.kind = ogs_pkg::K_QFIX;
               push_data.flag = 1'b1;
            end else begin
               push_data.kind = ogs_pkg::K_QSCAN;
            end
         end
         default: begin
            push_data.kind = ogs_pkg::K_NBR;
            push_data.r_lo = item_ff.cell_row;
            push_data.c_lo = item_ff.cell_col;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ogs_pkg::F_IDLE;
         cnt_ff    <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         if (accept) begin
            cnt_ff <= '0;
         end else if (issue) begin
            cnt_ff <= cnt_ff + 3'd1;
         end
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      s1_diff_ff <= diff_in;
      s1_tag_ff  <= cnt_ff[1:0];
      s2_neg_ff  <= s1_diff_ff[ogs_pkg::DIFF_W-1];
      s2_mag_ff  <= mag_in;
      s2_tag_ff  <= s1_tag_ff;
      s3_prod_ff <= prod_in;
      s3_hi_ff   <= s2_mag_ff[ogs_pkg::MAG_W-1];
      s3_neg_ff  <= s2_neg_ff;
      s3_tag_ff  <= s2_tag_ff;
      s4_q_ff    <= q_in;
      s4_rem_ff  <= rem_in;
      s4_neg_ff  <= s3_neg_ff;
      s4_tag_ff  <= s3_tag_ff;
      if (s4_vld_ff) begin
         idx_ff[s4_tag_ff] <= idx_in;
      end
   end

endmodule

@@ rtl/ogs_queue.sv @@
`timescale 1ns / 1ps
// Two-entry command queue between the front and back ends.
// Uses ogs_pkg for the command type and depth.

module ogs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ogs_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output ogs_pkg::cmd_type pop_data
);

   ogs_pkg::cmd_type            entry_ff [ogs_pkg::QUEUE_DEPTH];
   logic [ogs_pkg::QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [ogs_pkg::QCNT_W-1:0]  count_ff;
   logic                        do_push, do_pop;

   assign push_ready = count_ff < ogs_pkg::QCNT_W'(ogs_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/ogs_back.sv @@
`timescale 1ns / 1ps
// Back end: owns the cell bitmap (one RAM row per grid row), clears it after
// reset, executes marks, box scans and neighbour lookups. Uses ogs_pkg, ogs_ram.

module ogs_back (
   input  logic                     clock,
   input  logic                     reset,
   input  ogs_pkg::cfg_type         cfg,
   output ogs_pkg::back_status_type status,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  ogs_pkg::cmd_type         pop_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ogs_pkg::rsp_type         rsp_data
);

   ogs_pkg::back_state_type state_ff, state_in;
   ogs_pkg::cmd_type        cur_ff;
   logic [ogs_pkg::ROW_AW:0]      row_ff;
   logic                          chk_vld_ff;
   logic                          hit_ff;
   logic [ogs_pkg::MAX_COLS-1:0]  mask_ff, mask_in;
   logic [3:0]                    free_ff;
   logic [1:0]                    ph_ff;
   logic                          rsp_valid_ff;
   ogs_pkg::rsp_type              rsp_data_ff, rsp_in;
   logic                          rsp_load;

   logic                          wr_en;
   logic [ogs_pkg::ROW_AW-1:0]    wr_addr, rd_addr;
   logic [ogs_pkg::MAX_COLS-1:0]  wr_data, rd_data;

   logic                          out_free, do_pop, scan_issue, scan_hit;
   logic [ogs_pkg::USED_W-1:0]    r9, c9;
   logic                          up_in, dn_in, lf_in, rt_in;
   logic [ogs_pkg::ROW_AW-1:0]    r_up, r_dn;
   logic [ogs_pkg::COL_AW-1:0]    c_lf, c_rt;
   logic [1:0]                    pick_dir;
   logic [3:0]                    rest;
   logic                          nb_last;

   ogs_ram #(
      .WIDTH (ogs_pkg::MAX_COLS),
      .DEPTH (ogs_pkg::MAX_ROWS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign scan_issue = row_ff <= {1'b0, cur_ff.r_hi};
   assign scan_hit   = chk_vld_ff && (|(rd_data & mask_ff));
   assign mask_in    = ({ogs_pkg::MAX_COLS{1'b1}} << pop_data.c_lo)
                     & ({ogs_pkg::MAX_COLS{1'b1}} >> (ogs_pkg::COL_AW'(ogs_pkg::MAX_COLS - 1)
                                                      - pop_data.c_hi));

   // Neighbour geometry; wrapped addresses are masked by the inside flags
   always_comb begin
      r9    = ogs_pkg::USED_W'(cur_ff.r_lo);
      c9    = ogs_pkg::USED_W'(cur_ff.c_lo);
      r_up  = cur_ff.r_lo + 1'b1;
      r_dn  = cur_ff.r_lo - 1'b1;
      c_lf  = cur_ff.c_lo - 1'b1;
      c_rt  = cur_ff.c_lo + 1'b1;
      up_in = (r9 + 1'b1 < cfg.rows_used) && (c9 < cfg.cols_used);
      dn_in = (r9 != '0) && (r9 - 1'b1 < cfg.rows_used) && (c9 < cfg.cols_used);
      lf_in = (r9 < cfg.rows_used) && (c9 != '0) && (c9 - 1'b1 < cfg.cols_used);
      rt_in = (r9 < cfg.rows_used) && (c9 + 1'b1 < cfg.cols_used);
   end

   // Lowest pending direction goes out first
   always_comb begin
      if (free_ff[0]) begin
         pick_dir = ogs_pkg::DIR_UP;
      end else if (free_ff[1]) begin
         pick_dir = ogs_pkg::DIR_DOWN;
      end else if (free_ff[2]) begin
         pick_dir = ogs_pkg::DIR_LEFT;
      end else begin
         pick_dir = ogs_pkg::DIR_RIGHT;
      end
      rest    = free_ff & ~(4'b0001 << pick_dir);
      nb_last = (rest == 4'b0000);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ogs_pkg::B_CLEAR: begin
            if (row_ff == (ogs_pkg::ROW_AW + 1)'(ogs_pkg::MAX_ROWS - 1)) begin
               state_in = ogs_pkg::B_IDLE;
            end
         end
         ogs_pkg::B_IDLE: begin
            if (pop_valid) begin
               case (pop_data.kind)
                  ogs_pkg::K_MARK:  state_in = ogs_pkg::B_MARK_RD;
                  ogs_pkg::K_QSCAN: state_in = ogs_pkg::B_SCAN;
                  ogs_pkg::K_NBR:   state_in = ogs_pkg::B_NB_RD;
                  default:          state_in = ogs_pkg::B_RESP;
               endcase
            end
         end
         ogs_pkg::B_MARK_RD: state_in = ogs_pkg::B_MARK_WR;
         ogs_pkg::B_MARK_WR: state_in = ogs_pkg::B_RESP;
         ogs_pkg::B_RESP: begin
            if (out_free) begin
               state_in = ogs_pkg::B_IDLE;
            end
         end
         ogs_pkg::B_SCAN: begin
            if (!scan_issue && !chk_vld_ff) begin
               state_in = ogs_pkg::B_RESP;
            end
         end
         ogs_pkg::B_NB_RD: state_in = ogs_pkg::B_NB_CHK;
         ogs_pkg::B_NB_CHK: begin
            state_in = (ph_ff == 2'd2) ? ogs_pkg::B_NB_OUT : ogs_pkg::B_NB_RD;
         end
         ogs_pkg::B_NB_OUT: begin
            if (out_free && (free_ff == 4'b0000 || nb_last)) begin
               state_in = ogs_pkg::B_IDLE;
            end
         end
         default: state_in = ogs_pkg::B_IDLE;
      endcase
   end

   // Outputs: clearing status, RAM control, queue pop and result load
   always_comb begin
      status.clearing = 1'b0;
      pop_ready       = 1'b0;
      wr_en           = 1'b0;
      wr_addr         = cur_ff.r_lo;
      wr_data         = rd_data;
      rd_addr         = row_ff[ogs_pkg::ROW_AW-1:0];
      rsp_load        = 1'b0;
      rsp_in          = '0;
      rsp_in.last     = 1'b1;
      case (state_ff)
         ogs_pkg::B_CLEAR: begin
            status.clearing = 1'b1;
            wr_en           = 1'b1;
            wr_addr         = row_ff[ogs_pkg::ROW_AW-1:0];
            wr_data         = '0;
         end
         ogs_pkg::B_IDLE: pop_ready = 1'b1;
         ogs_pkg::B_MARK_RD: rd_addr = cur_ff.r_lo;
         ogs_pkg::B_MARK_WR: begin
            wr_en                = 1'b1;
            wr_data[cur_ff.c_lo] = cur_ff.flag;
         end
         ogs_pkg::B_RESP: begin
            rsp_load   = out_free;
            rsp_in.hit = hit_ff;
         end
         ogs_pkg::B_NB_RD: begin
            case (ph_ff)
               2'd0:    rd_addr = r_up;
               2'd1:    rd_addr = r_dn;
               default: rd_addr = cur_ff.r_lo;
            endcase
         end
         ogs_pkg::B_NB_OUT: begin
            rsp_load = out_free;
            if (free_ff != 4'b0000) begin
               rsp_in.nbr_found = 1'b1;
               rsp_in.nbr_dir   = pick_dir;
               rsp_in.last      = nb_last;
               case (pick_dir)
                  ogs_pkg::DIR_UP:   rsp_in.nbr_row = r_up;
                  ogs_pkg::DIR_DOWN: rsp_in.nbr_row = r_dn;
                  default:           rsp_in.nbr_row = cur_ff.r_lo;
               endcase
               case (pick_dir)
                  ogs_pkg::DIR_LEFT:  rsp_in.nbr_col = c_lf;
                  ogs_pkg::DIR_RIGHT: rsp_in.nbr_col = c_rt;
                  default:            rsp_in.nbr_col = cur_ff.c_lo;
               endcase
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ogs_pkg::B_CLEAR;
         row_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         ph_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ogs_pkg::B_CLEAR: row_ff <= row_ff + 1'b1;
            ogs_pkg::B_IDLE: begin
               if (do_pop) begin
                  row_ff <= {1'b0, pop_data.r_lo};
                  ph_ff  <= '0;
               end
            end
            ogs_pkg::B_SCAN: row_ff <= row_ff + (ogs_pkg::ROW_AW + 1)'(scan_issue);
            ogs_pkg::B_NB_CHK: ph_ff <= ph_ff + 2'd1;
            default: ;
         endcase
         chk_vld_ff <= (state_ff == ogs_pkg::B_SCAN) && scan_issue;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (do_pop) begin
         cur_ff  <= pop_data;
         mask_ff <= mask_in;
         free_ff <= 4'b0000;
         hit_ff  <= (pop_data.kind == ogs_pkg::K_QFIX) && pop_data.flag;
      end
      if (scan_hit) begin
         hit_ff <= 1'b1;
      end
      if (state_ff == ogs_pkg::B_NB_CHK) begin
         case (ph_ff)
            2'd0: free_ff[0] <= up_in && !rd_data[cur_ff.c_lo];
            2'd1: free_ff[1] <= dn_in && !rd_data[cur_ff.c_lo];
            default: begin
               free_ff[2] <= lf_in && !rd_data[c_lf];
               free_ff[3] <= rt_in && !rd_data[c_rt];
            end
         endcase
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_in;
         if (state_ff == ogs_pkg::B_NB_OUT) begin
            free_ff <= rest;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/occupancy_grid_store.sv @@
`timescale 1ns / 1ps
// Occupancy grid store, top level: configuration registers and the
// front end, command queue and back end. Uses ogs_pkg and all ogs_ modules.
//
// Usage:
//   req_*  : valid/ready input of items (mark occupied, mark free, box query,
//            free-neighbour query). rsp_*: valid/ready results; last marks the
//            final result of an item. csr_*: write-only registers, written
//            with csr_we while no item is outstanding.
//   Box queries scan one grid row of the box per cycle; neighbour queries
//   give their results one per cycle while rsp_ready stays high.
//   The front end takes a new item only once it has pushed the last one
//   (coordinate items pass four offsets through the five-stage index
//   multiplier). The back end works one item at a time and sets the pace
//   for long scans; a two-entry queue lets the two overlap.
//   Reset: registers return to their defaults and the bitmap is cleared one
//   row per cycle until every row is clear, with req_ready low throughout.
//   Stall: results wait in the output register while rsp_ready is low; the
//   back end and then the front end hold, and req_ready drops.

module occupancy_grid_store (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ogs_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ogs_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [ogs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ogs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic signed [31:0]              origin_x_ff, origin_y_ff;
   logic [31:0]                     inv_cell_ff;
   logic [ogs_pkg::USED_W-1:0]      num_rows_ff, num_cols_ff;
   ogs_pkg::cfg_type                cfg;
   ogs_pkg::back_status_type        status;
   logic                            push_valid, push_ready, pop_valid, pop_ready;
   ogs_pkg::cmd_type                push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         inv_cell_ff <= 32'd65536;
         num_rows_ff <= ogs_pkg::USED_W'(256);
         num_cols_ff <= ogs_pkg::USED_W'(256);
      end else if (csr_we) begin
         case (csr_index)
            ogs_pkg::REG_ORIGIN_X: origin_x_ff <= csr_wdata;
            ogs_pkg::REG_ORIGIN_Y: origin_y_ff <= csr_wdata;
            ogs_pkg::REG_INV_CELL: inv_cell_ff <= csr_wdata;
            ogs_pkg::REG_NUM_ROWS: num_rows_ff <= csr_wdata[ogs_pkg::USED_W-1:0];
            ogs_pkg::REG_NUM_COLS: num_cols_ff <= csr_wdata[ogs_pkg::USED_W-1:0];
            default: ;
         endcase
      end
   end

   // Cap rows and columns in use at the grid size
   always_comb begin
      cfg.origin_x      = origin_x_ff;
      cfg.origin_y      = origin_y_ff;
      cfg.inv_cell_size = inv_cell_ff;
      cfg.rows_used     = (num_rows_ff > ogs_pkg::USED_W'(ogs_pkg::MAX_ROWS))
                        ? ogs_pkg::USED_W'(ogs_pkg::MAX_ROWS) : num_rows_ff;
      cfg.cols_used     = (num_cols_ff > ogs_pkg::USED_W'(ogs_pkg::MAX_COLS))
                        ? ogs_pkg::USED_W'(ogs_pkg::MAX_COLS) : num_cols_ff;
   end

   ogs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .status     (status),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ogs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ogs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .status    (status),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
